@@ design/i2crm_pkg.sv @@
// shared types and constants for the i2c register master
// no dependencies; the top, front end and sequencer refer to it by scoped names
package i2crm_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_LIMIT = 1'd1;

  localparam logic [15:0] DELAY_RESET    = 16'd350;
  localparam logic [7:0]  ACK_WAIT_RESET = 8'd50;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] write_data;
    logic       write_valid;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_low;
    logic       data_request;
    logic       read_valid;
    logic [7:0] read_data;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } res_t;

  typedef struct packed {
    logic [15:0] delay_ticks;
    logic [7:0]  ack_wait_limit;
  } cfg_t;

  // queue to sequencer handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [17:0] {
    PH_IDLE        = 18'h00001,
    PH_START_HIGH  = 18'h00002,
    PH_START_FALL  = 18'h00004,
    PH_RESTART_LOW = 18'h00008,
    PH_TX_LOW      = 18'h00010,
    PH_TX_HIGH     = 18'h00020,
    PH_ACK_LOW     = 18'h00040,
    PH_ACK_HIGH    = 18'h00080,
    PH_WAIT_DATA   = 18'h00100,
    PH_RX_LOW      = 18'h00200,
    PH_RX_HIGH     = 18'h00400,
    PH_MACK_LOW    = 18'h00800,
    PH_MACK_HIGH   = 18'h01000,
    PH_NACK_LOW    = 18'h02000,
    PH_NACK_HIGH   = 18'h04000,
    PH_STOP_LOW    = 18'h08000,
    PH_STOP_HIGH   = 18'h10000,
    PH_STOP_END    = 18'h20000
  } phase_t;

  typedef enum logic [3:0] {
    ST_ADDR  = 4'b0001,
    ST_REG   = 4'b0010,
    ST_RADDR = 4'b0100,
    ST_DATA  = 4'b1000
  } stage_t;

endpackage

@@ design/i2crm_in_if.sv @@
// request channel of the i2c register master: valid/ready plus one tick's fields
// no dependencies
interface i2crm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] length;
  logic [7:0] write_data;
  logic       write_valid;
  logic       sda_in;

  modport source (output valid, func, dev_addr, reg_addr, length, write_data,
                  write_valid, sda_in, input ready);
  modport sink (input valid, func, dev_addr, reg_addr, length, write_data,
                write_valid, sda_in, output ready);
endinterface

@@ design/i2crm_out_if.sv @@
// result channel of the i2c register master: valid/ready plus pin and status fields
// no dependencies
interface i2crm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_low;
  logic       data_request;
  logic       read_valid;
  logic [7:0] read_data;
  logic       busy_res;
  logic       done_res;
  logic       status;

  modport source (output valid, scl_out, sda_low, data_request, read_valid, read_data,
                  busy_res, done_res, status, input ready);
  modport sink (input valid, scl_out, sda_low, data_request, read_valid, read_data,
                busy_res, done_res, status, output ready);
endinterface

@@ design/i2c_register_master.sv @@
// i2c register master: one request per system tick, one result per request
// an accepted request is written into the queue, then its result into the output register
// throughput: one request per cycle while out_if.ready does not stall the result register
// reset: sequencer idle, queue and output register empty, delay 350, ack wait 50
// depends on i2crm_pkg, i2crm_in_if, i2crm_out_if, i2crm_front and i2crm_seq
module i2c_register_master (
  input  logic                                 clk,
  input  logic                                 rst_n,
  i2crm_in_if.sink                             in_if,
  i2crm_out_if.source                          out_if,
  input  logic                                 cfg_we,
  input  logic [i2crm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2crm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  i2crm_pkg::cfg_t    cfg_r, cfg_nxt;
  i2crm_pkg::q_head_t head;
  logic               pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        i2crm_pkg::CFG_DELAY_TICKS:    cfg_nxt.delay_ticks    = cfg_data;
        i2crm_pkg::CFG_ACK_WAIT_LIMIT: cfg_nxt.ack_wait_limit = cfg_data[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ticks    <= i2crm_pkg::DELAY_RESET;
      cfg_r.ack_wait_limit <= i2crm_pkg::ACK_WAIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  i2crm_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .pop   (pop),
    .head  (head)
  );

  i2crm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

@@ design/i2crm_front.sv @@
// front end: accepts requests, decodes the command and holds them in a two-entry queue
// depends on i2crm_pkg and i2crm_in_if
module i2crm_front (
  input  logic               clk,
  input  logic               rst_n,
  i2crm_in_if.sink           in_if,
  input  logic               pop,
  output i2crm_pkg::q_head_t head
);

  i2crm_pkg::item_t q_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  i2crm_pkg::cmd_t  cmd;
  i2crm_pkg::item_t item;

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;

  // command decode; the unused codes behave like no command
  always_comb begin
    unique case (in_if.func)
      i2crm_pkg::FUNC_WRITE: cmd = i2crm_pkg::CMD_WRITE;
      i2crm_pkg::FUNC_READ:  cmd = i2crm_pkg::CMD_READ;
      default:               cmd = i2crm_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    item.cmd         = cmd;
    item.dev_addr    = in_if.dev_addr;
    item.reg_addr    = in_if.reg_addr;
    item.length      = in_if.length;
    item.write_data  = in_if.write_data;
    item.write_valid = in_if.write_valid;
    item.sda_in      = in_if.sda_in;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

endmodule

@@ design/i2crm_seq.sv @@
// back end: pin phase sequencer, one queued tick per cycle unless the result is stalled, with registered result
// depends on i2crm_pkg and i2crm_out_if
module i2crm_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  i2crm_pkg::cfg_t    cfg,
  input  i2crm_pkg::q_head_t head,
  output logic               pop,
  i2crm_out_if.source        out_if
);

  i2crm_pkg::phase_t state_r, state_nxt;
  i2crm_pkg::stage_t stage_r, stage_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  ackw_r, ackw_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic        rd_r, rd_nxt;
  logic        err_r, err_nxt;

  logic            out_valid_r, out_valid_nxt;
  i2crm_pkg::res_t res_r, res_nxt;

  logic        rx_pulse;
  logic [7:0]  rx_byte;
  logic        done;
  logic [15:0] tick_inc;
  logic [15:0] lim;
  logic [7:0]  rx_shift;
  logic [7:0]  left_dec;
  logic        scl;
  logic        pull;
  i2crm_pkg::item_t it;

  assign it  = head.item;
  assign pop = head.valid && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    ackw_nxt  = ackw_r;
    dev_nxt   = dev_r;
    reg_nxt   = reg_r;
    rd_nxt    = rd_r;
    err_nxt   = err_r;
    rx_pulse  = 1'b0;
    rx_byte   = 8'd0;
    done      = 1'b0;
    tick_inc  = tick_r + 16'd1;
    lim       = (cfg.delay_ticks == 16'd0) ? 16'd1 : cfg.delay_ticks;
    rx_shift  = {shift_r[6:0], it.sda_in};
    left_dec  = left_r - 8'd1;

    if (state_r == i2crm_pkg::PH_IDLE) begin
      tick_nxt = 16'd0;
      if (it.cmd != i2crm_pkg::CMD_NONE) begin
        dev_nxt   = it.dev_addr;
        reg_nxt   = it.reg_addr;
        left_nxt  = it.length;
        rd_nxt    = (it.cmd == i2crm_pkg::CMD_READ);
        stage_nxt = i2crm_pkg::ST_ADDR;
        err_nxt   = 1'b0;
        bit_nxt   = 3'd0;
        shift_nxt = 8'd0;
        ackw_nxt  = 8'd0;
        state_nxt = i2crm_pkg::PH_START_HIGH;
      end
    end else if (state_r == i2crm_pkg::PH_WAIT_DATA) begin
      tick_nxt = 16'd0;
      if (it.write_valid) begin
        shift_nxt = it.write_data;
        bit_nxt   = 3'd0;
        state_nxt = i2crm_pkg::PH_TX_LOW;
      end
    end else begin
      tick_nxt = tick_inc;
      if (tick_inc >= lim) begin
        tick_nxt = 16'd0;
        // end of a timed phase
        unique case (state_r)
          i2crm_pkg::PH_START_HIGH:  state_nxt = i2crm_pkg::PH_START_FALL;
          i2crm_pkg::PH_RESTART_LOW: state_nxt = i2crm_pkg::PH_START_HIGH;
          i2crm_pkg::PH_START_FALL: begin
            shift_nxt = (stage_r == i2crm_pkg::ST_RADDR) ? (dev_r | 8'h01) : dev_r;
            bit_nxt   = 3'd0;
            state_nxt = i2crm_pkg::PH_TX_LOW;
          end
          i2crm_pkg::PH_TX_LOW: state_nxt = i2crm_pkg::PH_TX_HIGH;
          i2crm_pkg::PH_TX_HIGH: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            if (bit_r == 3'd7) begin
              bit_nxt   = 3'd0;
              ackw_nxt  = 8'd0;
              state_nxt = i2crm_pkg::PH_ACK_LOW;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              state_nxt = i2crm_pkg::PH_TX_LOW;
            end
          end
          i2crm_pkg::PH_ACK_LOW: begin
            if (!it.sda_in) begin
              state_nxt = i2crm_pkg::PH_ACK_HIGH;
            end else if (ackw_r < cfg.ack_wait_limit) begin
              ackw_nxt = ackw_r + 8'd1;
            end else begin
              // slave never acked: abort with stop
              err_nxt   = 1'b1;
              state_nxt = i2crm_pkg::PH_STOP_LOW;
            end
          end
          i2crm_pkg::PH_ACK_HIGH: begin
            unique case (stage_r)
              i2crm_pkg::ST_ADDR: begin
                stage_nxt = i2crm_pkg::ST_REG;
                shift_nxt = reg_r;
                bit_nxt   = 3'd0;
                state_nxt = i2crm_pkg::PH_TX_LOW;
              end
              i2crm_pkg::ST_REG: begin
                if (rd_r) begin
                  stage_nxt = i2crm_pkg::ST_RADDR;
                  state_nxt = i2crm_pkg::PH_RESTART_LOW;
                end else if (left_r != 8'd0) begin
                  stage_nxt = i2crm_pkg::ST_DATA;
                  state_nxt = i2crm_pkg::PH_WAIT_DATA;
                end else begin
                  state_nxt = i2crm_pkg::PH_STOP_LOW;
                end
              end
              i2crm_pkg::ST_RADDR: begin
                if (left_r != 8'd0) begin
                  shift_nxt = 8'd0;
                  bit_nxt   = 3'd0;
                  state_nxt = i2crm_pkg::PH_RX_LOW;
                end else begin
                  state_nxt = i2crm_pkg::PH_STOP_LOW;
                end
              end
              default: begin
                left_nxt  = left_dec;
                state_nxt = (left_dec != 8'd0) ? i2crm_pkg::PH_WAIT_DATA
                                               : i2crm_pkg::PH_STOP_LOW;
              end
            endcase
          end
          i2crm_pkg::PH_RX_LOW: state_nxt = i2crm_pkg::PH_RX_HIGH;
          i2crm_pkg::PH_RX_HIGH: begin
            shift_nxt = rx_shift;
            if (bit_r == 3'd7) begin
              bit_nxt   = 3'd0;
              rx_pulse  = 1'b1;
              rx_byte   = rx_shift;
              left_nxt  = left_dec;
              state_nxt = (left_dec != 8'd0) ? i2crm_pkg::PH_MACK_LOW
                                             : i2crm_pkg::PH_NACK_LOW;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              state_nxt = i2crm_pkg::PH_RX_LOW;
            end
          end
          i2crm_pkg::PH_MACK_LOW: state_nxt = i2crm_pkg::PH_MACK_HIGH;
          i2crm_pkg::PH_MACK_HIGH: begin
            shift_nxt = 8'd0;
            state_nxt = i2crm_pkg::PH_RX_LOW;
          end
          i2crm_pkg::PH_NACK_LOW:  state_nxt = i2crm_pkg::PH_NACK_HIGH;
          i2crm_pkg::PH_NACK_HIGH: state_nxt = i2crm_pkg::PH_STOP_LOW;
          i2crm_pkg::PH_STOP_LOW:  state_nxt = i2crm_pkg::PH_STOP_HIGH;
          i2crm_pkg::PH_STOP_HIGH: state_nxt = i2crm_pkg::PH_STOP_END;
          default: begin
            state_nxt = i2crm_pkg::PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end
    end
  end

  // pin levels follow the phase after this tick
  always_comb begin
    unique case (state_nxt)
      i2crm_pkg::PH_IDLE, i2crm_pkg::PH_START_HIGH, i2crm_pkg::PH_RX_HIGH,
      i2crm_pkg::PH_NACK_HIGH, i2crm_pkg::PH_STOP_END, i2crm_pkg::PH_ACK_HIGH: begin
        scl  = 1'b1;
        pull = 1'b0;
      end
      i2crm_pkg::PH_START_FALL, i2crm_pkg::PH_MACK_HIGH, i2crm_pkg::PH_STOP_HIGH: begin
        scl  = 1'b1;
        pull = 1'b1;
      end
      i2crm_pkg::PH_TX_LOW: begin
        scl  = 1'b0;
        pull = ~shift_nxt[7];
      end
      i2crm_pkg::PH_TX_HIGH: begin
        scl  = 1'b1;
        pull = ~shift_nxt[7];
      end
      i2crm_pkg::PH_MACK_LOW, i2crm_pkg::PH_STOP_LOW: begin
        scl  = 1'b0;
        pull = 1'b1;
      end
      default: begin
        scl  = 1'b0;
        pull = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_nxt.scl_out      = scl;
    res_nxt.sda_low      = pull;
    res_nxt.data_request = (state_nxt == i2crm_pkg::PH_WAIT_DATA);
    res_nxt.read_valid   = rx_pulse;
    res_nxt.read_data    = rx_byte;
    res_nxt.busy_res     = (state_nxt != i2crm_pkg::PH_IDLE);
    res_nxt.done_res     = done;
    res_nxt.status       = done && err_nxt;
    out_valid_nxt        = pop || (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2crm_pkg::PH_IDLE;
      stage_r     <= i2crm_pkg::ST_ADDR;
      tick_r      <= 16'd0;
      bit_r       <= 3'd0;
      shift_r     <= 8'd0;
      left_r      <= 8'd0;
      ackw_r      <= 8'd0;
      dev_r       <= 8'd0;
      reg_r       <= 8'd0;
      rd_r        <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        state_r <= state_nxt;
        stage_r <= stage_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        left_r  <= left_nxt;
        ackw_r  <= ackw_nxt;
        dev_r   <= dev_nxt;
        reg_r   <= reg_nxt;
        rd_r    <= rd_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.scl_out      = res_r.scl_out;
  assign out_if.sda_low      = res_r.sda_low;
  assign out_if.data_request = res_r.data_request;
  assign out_if.read_valid   = res_r.read_valid;
  assign out_if.read_data    = res_r.read_data;
  assign out_if.busy_res     = res_r.busy_res;
  assign out_if.done_res     = res_r.done_res;
  assign out_if.status       = res_r.status;

endmodule
